// ===== rtl/heavy_keeper_bucket_update_macros.svh =====
// assertion macros for the bucket update block
`ifndef HEAVY_KEEPER_BUCKET_UPDATE_MACROS_SVH
`define HEAVY_KEEPER_BUCKET_UPDATE_MACROS_SVH

// implication checked on every edge outside reset
`define HKBU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that holds on every edge outside reset
`define HKBU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> (cond)) \
		else $error(msg);

`endif

// ===== rtl/hkbu_pkg.sv =====
// shared types, action codes and decay threshold table
package hkbu_pkg;

	localparam int unsigned FP_W = 16;
	localparam int unsigned MAX_ROWS = 4;
	localparam int unsigned COL_IDX_W = 16;
	localparam int unsigned KCNT_W = 18;
	localparam int unsigned DECAY_LEN = 289;
	localparam int unsigned BIG_W = 1408;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_UPDATE = 2'd1;
	localparam logic [1:0] ACT_PUSH = 2'd2;

	typedef logic [32:0] decay_rom_t [DECAY_LEN];

	typedef struct packed {
		logic [MAX_ROWS-1:0][COL_IDX_W-1:0] col;
		logic [FP_W-1:0] fp;
		logic [31:0] rnd;
		logic found;
		logic [KCNT_W-1:0] kcount;
		logic [KCNT_W-1:0] smin;
		logic empty_store;
		logic full_store;
	} item_t;

	// floor(2^32 * (25/27)^c), exact, by shift and subtract
	function automatic decay_rom_t build_decay_rom();
		decay_rom_t rom;
		logic [BIG_W-1:0] num;
		logic [BIG_W-1:0] den;
		logic [BIG_W-1:0] rest;
		logic [32:0] quo;
		num = BIG_W'(1) << 32;
		den = BIG_W'(1);
		for (int c = 0; c < DECAY_LEN; c++) begin
			rest = num;
			quo = '0;
			for (int b = 32; b >= 0; b--) begin
				if (rest >= (den << b)) begin
					rest = rest - (den << b);
					quo[b] = 1'b1;
				end
			end
			rom[c] = quo;
			num = num * BIG_W'(25);
			den = den * BIG_W'(27);
		end
		return rom;
	endfunction

endpackage

// ===== rtl/hkbu_front.sv =====
// front end: column reduction of the hash words and item classification
module hkbu_front #(
	parameter int unsigned ROW_NUM = 2,
	parameter int unsigned COL_NUM = 16384
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [hkbu_pkg::MAX_ROWS-1:0][31:0] hashes,
	input  logic [31:0] random_word,
	input  logic key_found,
	input  logic [hkbu_pkg::KCNT_W-1:0] key_count,
	input  logic [hkbu_pkg::KCNT_W-1:0] store_min,
	input  logic [1:0] store_state,
	input  logic hold,
	output logic push,
	input  logic push_ready,
	output hkbu_pkg::item_t push_item
);
	import hkbu_pkg::*;

	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / COL_NUM);
	localparam logic [16:0] COLS = 17'(COL_NUM);

	logic v_s1, v_s2, en_s1, en_s2;
	logic [MAX_ROWS-1:0][31:0] h_s1;
	logic [MAX_ROWS-1:0][31:0] q_s1;
	logic [MAX_ROWS-1:0][17:0] rem_s2;
	item_t it_s1, it_s2;
	item_t it_in;
	logic [MAX_ROWS-1:0][31:0] q_c;
	logic [MAX_ROWS-1:0][17:0] rem_c;
	logic [64:0] prod1;
	logic [63:0] diff;

	assign en_s2 = !v_s2 || push_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1 && !hold;
	assign push = v_s2 && push_ready;

	always_comb begin
		it_in = '0;
		it_in.fp = hashes[2][FP_W-1:0];
		it_in.rnd = random_word;
		it_in.found = key_found;
		it_in.kcount = key_count;
		it_in.smin = store_min;
		it_in.empty_store = (store_state == 2'd0);
		it_in.full_store = store_state[1];
		q_c = '0;
		for (int r = 0; r < ROW_NUM; r++) begin
			prod1 = 65'(hashes[r]) * 65'(RECIP);
			q_c[r] = prod1[63:32];
		end
	end

	always_comb begin
		rem_c = '0;
		for (int r = 0; r < ROW_NUM; r++) begin
			diff = 64'(h_s1[r]) - 64'(q_s1[r]) * 64'(COLS);
			rem_c[r] = diff[17:0];
		end
	end

	always_comb begin
		push_item = it_s2;
		for (int r = 0; r < ROW_NUM; r++) begin
			if (rem_s2[r] >= 18'(COLS))
				push_item.col[r] = COL_IDX_W'(rem_s2[r] - 18'(COLS));
			else
				push_item.col[r] = COL_IDX_W'(rem_s2[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= in_valid && in_ready;
			if (en_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid && in_ready) begin
			h_s1 <= hashes;
			q_s1 <= q_c;
			it_s1 <= it_in;
		end
		if (en_s2 && v_s1) begin
			rem_s2 <= rem_c;
			it_s2 <= it_s1;
		end
	end

endmodule

// ===== rtl/hkbu_queue.sv =====
// short queue of classified items between front and back
module hkbu_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  hkbu_pkg::item_t push_item,
	input  logic pop,
	output logic pop_valid,
	output hkbu_pkg::item_t pop_item
);
	import hkbu_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	item_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign push_ready = (count_q != (PTR_W+1)'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/hkbu_back.sv =====
// back end: bucket memories, update decision, write back and result register
module hkbu_back #(
	parameter int unsigned ROW_NUM = 2,
	parameter int unsigned COL_NUM = 16384,
	parameter int unsigned COUNTER_BITS = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  hkbu_pkg::item_t q_item,
	output logic clear_busy,
	output logic out_valid,
	input  logic out_ready,
	output logic [17:0] estimate,
	output logic [1:0] action
);
	import hkbu_pkg::*;

	localparam int unsigned COL_W = (COL_NUM > 1) ? $clog2(COL_NUM) : 1;
	localparam int unsigned CNT_W = COUNTER_BITS;
	localparam int unsigned ENT_W = FP_W + CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam decay_rom_t DECAY_ROM = build_decay_rom();

	logic v_s1, en_s1, fire_s1, out_en;
	item_t it_s1;
	logic [ENT_W-1:0] cur [ROW_NUM];
	logic [COL_W-1:0] clr_cnt_q;
	logic clr_q;
	logic out_v_q;
	logic [17:0] est_q;
	logic [1:0] act_q;

	logic added, have_empty, have_min, decay_hit, wr_any;
	logic [1:0] inc_r, empty_r, min_r, wr_row;
	logic [CNT_W-1:0] est, min_cnt, cnt, inc_cnt;
	logic [FP_W-1:0] min_fp;
	logic [ENT_W-1:0] wr_ent;
	logic [31:0] est32, min32;
	logic [32:0] thr;
	logic [1:0] act_c;

	assign out_en = !out_v_q || out_ready;
	assign en_s1 = !v_s1 || out_en;
	assign q_pop = q_valid && en_s1 && !clr_q;
	assign fire_s1 = v_s1 && out_en;
	assign clear_busy = clr_q;
	assign out_valid = out_v_q;
	assign estimate = est_q;
	assign action = act_q;

	always_comb begin
		added = 1'b0;
		have_empty = 1'b0;
		have_min = 1'b0;
		est = '0;
		min_cnt = '0;
		min_fp = '0;
		empty_r = '0;
		min_r = '0;
		inc_r = '0;
		inc_cnt = '0;
		cnt = '0;
		for (int r = 0; r < ROW_NUM; r++) begin
			cnt = cur[r][CNT_W-1:0];
			if (!added) begin
				if (cnt == '0) begin
					if (!have_empty) begin
						have_empty = 1'b1;
						empty_r = 2'(r);
					end
				end else if (cur[r][ENT_W-1:CNT_W] == it_s1.fp) begin
					if (it_s1.found || it_s1.empty_store || 32'(cnt) <= 32'(it_s1.smin)) begin
						added = 1'b1;
						inc_r = 2'(r);
						inc_cnt = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
						est = inc_cnt;
					end else if (cnt > est) begin
						est = cnt;
					end
				end else if (!have_min || cnt < min_cnt) begin
					have_min = 1'b1;
					min_cnt = cnt;
					min_fp = cur[r][ENT_W-1:CNT_W];
					min_r = 2'(r);
				end
			end
		end

		min32 = 32'(min_cnt);
		thr = (min32 < 32'(DECAY_LEN)) ? DECAY_ROM[min32[8:0]] : 33'd0;
		decay_hit = have_min && ({1'b0, it_s1.rnd} < thr);

		wr_any = 1'b0;
		wr_row = '0;
		wr_ent = '0;
		if (added) begin
			wr_any = 1'b1;
			wr_row = inc_r;
			wr_ent = {it_s1.fp, inc_cnt};
		end else if (have_empty) begin
			wr_any = 1'b1;
			wr_row = empty_r;
			wr_ent = {it_s1.fp, CNT_W'(1)};
			est = CNT_W'(1);
		end else if (decay_hit) begin
			wr_any = 1'b1;
			wr_row = min_r;
			if (min_cnt == CNT_W'(1)) begin
				wr_ent = {it_s1.fp, min_cnt};
				est = CNT_W'(1);
			end else begin
				wr_ent = {min_fp, min_cnt - 1'b1};
			end
		end

		est32 = 32'(est);
		if (it_s1.found)
			act_c = (est32 > 32'(it_s1.kcount)) ? ACT_UPDATE : ACT_NONE;
		else if (!it_s1.full_store || (est32 - 32'(it_s1.smin)) == 32'd1)
			act_c = ACT_PUSH;
		else
			act_c = ACT_NONE;
	end

	for (genvar r = 0; r < ROW_NUM; r++) begin : g_row
		logic [ENT_W-1:0] mem_q [COL_NUM];
		logic we;
		logic [COL_W-1:0] wa;
		logic [ENT_W-1:0] wd;
		logic item_we;
		logic [ENT_W-1:0] rd_s1;
		logic fwd_v_q;
		logic [COL_W-1:0] fwd_col_q;
		logic [ENT_W-1:0] fwd_ent_q;

		assign item_we = fire_s1 && wr_any && (wr_row == 2'(r));
		assign we = clr_q || item_we;
		assign wa = clr_q ? clr_cnt_q : it_s1.col[r][COL_W-1:0];
		assign wd = clr_q ? '0 : wr_ent;
		assign cur[r] = (fwd_v_q && fwd_col_q == it_s1.col[r][COL_W-1:0]) ? fwd_ent_q : rd_s1;

		always_ff @(posedge clk) begin
			if (we)
				mem_q[wa] <= wd;
			if (q_pop)
				rd_s1 <= mem_q[q_item.col[r][COL_W-1:0]];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fwd_v_q <= 1'b0;
			end else if (item_we) begin
				fwd_v_q <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (item_we) begin
				fwd_col_q <= wa;
				fwd_ent_q <= wr_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == COL_W'(COL_NUM - 1))
					clr_q <= 1'b0;
			end
			if (en_s1)
				v_s1 <= q_pop;
			if (out_en)
				out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			it_s1 <= q_item;
		if (fire_s1) begin
			est_q <= est32[17:0];
			act_q <= act_c;
		end
	end

endmodule

// ===== rtl/heavy_keeper_bucket_update.sv =====
// Bucket update of a top-k heavy-hitter sketch: one item per clock cycle
// sustained while out_ready stays high. Front pipeline reduces each hash word
// to a column in two stages (multiply by reciprocal, then multiply back and
// correct), a four-entry queue decouples it from the back end, which reads one
// bucket per row from a single-port-write memory per row, decides and writes
// back in one stage, and forwards the last write per row so back-to-back items
// on the same bucket see fresh data. out_valid and the result come from an output
// register behind the two front stages, the queue and the back-end stage. After
// reset the bucket memories are cleared, and in_ready stays low during the clear.
module heavy_keeper_bucket_update #(
	parameter int unsigned ROW_NUM = 2,
	parameter int unsigned COL_NUM = 16384,
	parameter int unsigned COUNTER_BITS = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] row_hash_0,
	input  logic [31:0] row_hash_1,
	input  logic [31:0] row_hash_2,
	input  logic [31:0] row_hash_3,
	input  logic [31:0] random_word,
	input  logic key_found,
	input  logic [hkbu_pkg::KCNT_W-1:0] key_count,
	input  logic [hkbu_pkg::KCNT_W-1:0] store_min,
	input  logic [1:0] store_state,
	output logic out_valid,
	input  logic out_ready,
	output logic [17:0] estimate,
	output logic [1:0] action
);
	import hkbu_pkg::*;
	`include "heavy_keeper_bucket_update_macros.svh"

	logic [MAX_ROWS-1:0][31:0] hashes;
	logic push, push_ready, pop, pop_valid, clear_busy;
	item_t push_item, pop_item;

	assign hashes = {row_hash_3, row_hash_2, row_hash_1, row_hash_0};

	hkbu_front #(
		.ROW_NUM(ROW_NUM),
		.COL_NUM(COL_NUM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hashes(hashes),
		.random_word(random_word),
		.key_found(key_found),
		.key_count(key_count),
		.store_min(store_min),
		.store_state(store_state),
		.hold(clear_busy),
		.push(push),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	hkbu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_item(pop_item)
	);

	hkbu_back #(
		.ROW_NUM(ROW_NUM),
		.COL_NUM(COL_NUM),
		.COUNTER_BITS(COUNTER_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_pop(pop),
		.q_item(pop_item),
		.clear_busy(clear_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.estimate(estimate),
		.action(action)
	);

	`HKBU_ASSERT_IMP(a_no_accept_in_clear, clear_busy, !in_ready, "item accepted during clear")
	`HKBU_ASSERT_IMP(a_update_nonzero, out_valid && action == ACT_UPDATE, estimate != '0, "update with zero estimate")
	`HKBU_ASSERT_ALWAYS(a_no_pop_empty, !pop || pop_valid, "pop from empty queue")

endmodule

// ===== verif/heavy_keeper_bucket_update_tb.sv =====
// testbench for heavy_keeper_bucket_update: bucket update checked against its own sketch model
module heavy_keeper_bucket_update_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hkbu_pkg::*;

	localparam int unsigned ROWS = 2;
	localparam int unsigned COLS = 16384;
	localparam int unsigned CNT_W = 18;
	localparam logic [CNT_W-1:0] CNT_TOP = '1;
	localparam int unsigned THR_LEN = 289;
	localparam int unsigned WIDE_W = 1408;

	typedef struct {
		logic [31:0] h0, h1, h2, h3, rnd;
		logic found;
		logic [17:0] kcount, smin;
		logic [1:0] sstate;
	} sketch_item_t;

	typedef struct {
		logic [17:0] est;
		logic [1:0] act;
	} sketch_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] row_hash_0 = '0, row_hash_1 = '0, row_hash_2 = '0, row_hash_3 = '0;
	logic [31:0] random_word = '0;
	logic key_found = 1'b0;
	logic [17:0] key_count = '0, store_min = '0;
	logic [1:0] store_state = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [17:0] estimate;
	logic [1:0] action;

	heavy_keeper_bucket_update u_top (.*);

	always #5 clk = ~clk;

	sketch_item_t pending_q[$];
	sketch_result_t result_q[$];
	logic [15:0] fp_mem [ROWS*COLS];
	logic [CNT_W-1:0] cnt_mem [ROWS*COLS];
	logic [32:0] decay_thr [THR_LEN];
	int errors = 0, accepted = 0, checked = 0;
	int n_inc = 0, n_claim = 0, n_decay = 0, n_take = 0, n_push = 0, n_upd = 0;
	bit calm = 1'b0;

	// bucket update and store action for one transaction
	task automatic apply_item(input sketch_item_t it);
		logic [31:0] hw;
		logic [15:0] fp;
		int idx, e_idx, m_idx;
		logic [CNT_W-1:0] cnt, m_cnt, est;
		bit have_e, have_m, done;
		sketch_result_t res;
		fp = it.h2[15:0];
		have_e = 0; have_m = 0; done = 0;
		e_idx = 0; m_idx = 0; m_cnt = '0; est = '0;
		for (int r = 0; r < ROWS; r++) begin
			hw = (r == 0) ? it.h0 : (r == 1) ? it.h1 : (r == 2) ? it.h2 : it.h3;
			idx = r * COLS + int'(hw % COLS);
			cnt = cnt_mem[idx];
			if (cnt == 0) begin
				if (!have_e) begin
					have_e = 1;
					e_idx = idx;
				end
			end else if (fp_mem[idx] == fp) begin
				if (it.found || it.sstate == 0 || cnt <= it.smin) begin
					if (cnt != CNT_TOP) cnt++;
					cnt_mem[idx] = cnt;
					est = cnt;
					done = 1;
					n_inc++;
					break;
				end
				if (cnt > est) est = cnt;
			end else if (!have_m || cnt < m_cnt) begin
				have_m = 1;
				m_cnt = cnt;
				m_idx = idx;
			end
		end
		if (!done) begin
			if (have_e) begin
				fp_mem[e_idx] = fp;
				cnt_mem[e_idx] = CNT_W'(1);
				est = CNT_W'(1);
				n_claim++;
			end else if (have_m && m_cnt < THR_LEN && {1'b0, it.rnd} < decay_thr[m_cnt]) begin
				n_decay++;
				if (m_cnt == 1) begin
					fp_mem[m_idx] = fp;
					est = CNT_W'(1);
					n_take++;
				end else begin
					cnt_mem[m_idx] = m_cnt - 1'b1;
				end
			end
		end
		res.est = est;
		if (it.found)
			res.act = (est > it.kcount) ? ACT_UPDATE : ACT_NONE;
		else if (it.sstate < 2 || (32'(est) - 32'(it.smin)) == 32'd1)
			res.act = ACT_PUSH;
		else
			res.act = ACT_NONE;
		if (res.act == ACT_PUSH) n_push++;
		if (res.act == ACT_UPDATE) n_upd++;
		result_q = {result_q, res};
	endtask

	function automatic sketch_item_t make_item(logic [13:0] c0, logic [13:0] c1,
			logic [15:0] fp, logic [31:0] rnd, logic found, logic [17:0] kc,
			logic [17:0] sm, logic [1:0] ss);
		sketch_item_t it;
		it.h0 = {18'($urandom_range(0, 262143)), c0};
		it.h1 = {18'($urandom_range(0, 262143)), c1};
		it.h2 = {16'($urandom_range(0, 65535)), fp};
		it.h3 = $urandom;
		it.rnd = rnd;
		it.found = found;
		it.kcount = kc;
		it.smin = sm;
		it.sstate = ss;
		return it;
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		sketch_item_t it;
		if (in_valid && in_ready) begin
			it.h0 = row_hash_0; it.h1 = row_hash_1; it.h2 = row_hash_2; it.h3 = row_hash_3;
			it.rnd = random_word; it.found = key_found; it.kcount = key_count;
			it.smin = store_min; it.sstate = store_state;
			apply_item(it);
			accepted++;
		end
		if (arst_n && (!in_valid || in_ready)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				send_gap = $urandom_range(0, 10);
			end else if (pending_q.size() > 0) begin
				it = pending_q.pop_front();
				row_hash_0 <= it.h0; row_hash_1 <= it.h1;
				row_hash_2 <= it.h2; row_hash_3 <= it.h3;
				random_word <= it.rnd; key_found <= it.found; key_count <= it.kcount;
				store_min <= it.smin; store_state <= it.sstate;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	int recv_gap = 0;
	int hold_cnt = 0;
	bit held = 1'b0;
	always @(posedge clk) begin
		sketch_result_t exp_r;
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$display("%0t: transaction with nothing expected: estimate %0d action %0d",
					$time, estimate, action);
				errors++;
			end else begin
				exp_r = result_q.pop_front();
				checked++;
				if (estimate !== exp_r.est) begin
					$display("%0t: estimate expected %0d actual %0d", $time, exp_r.est, estimate);
					errors++;
				end
				if (action !== exp_r.act) begin
					$display("%0t: action expected %0d actual %0d", $time, exp_r.act, action);
					errors++;
				end
			end
		end
		if (!held && accepted >= 150) begin
			held = 1'b1;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			recv_gap = $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [WIDE_W-1:0] num, tmp;
		logic [13:0] kc0 [12];
		logic [13:0] kc1 [12];
		logic [15:0] kfp [12];
		logic [31:0] rnd;
		logic [17:0] kc, sm;
		int k, mode;
		num = WIDE_W'(1) << 32;
		for (int c = 0; c < THR_LEN; c++) begin
			tmp = num;
			for (int j = 0; j < c; j++) tmp = tmp / 27;
			decay_thr[c] = tmp[32:0];
			num = num * 25;
		end
		for (int i = 0; i < ROWS*COLS; i++) begin
			fp_mem[i] = '0;
			cnt_mem[i] = '0;
		end
		// directed: extremes, claims, matches, decay and takeover
		pending_q = {pending_q, make_item(14'h0000, 14'h0000, 16'h0000, 32'h0, 1'b0,
			18'd0, 18'd0, 2'd0)};
		pending_q = {pending_q, make_item(14'h3fff, 14'h3fff, 16'hffff, 32'hffffffff, 1'b1,
			18'h3ffff, 18'h3ffff, 2'd1)};
		pending_q = {pending_q, make_item(14'h3fff, 14'h3fff, 16'hffff, 32'h0, 1'b1,
			18'h0, 18'd0, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd1, 32'h0, 1'b0, 18'd0, 18'd0, 2'd0)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd2, 32'h0, 1'b0, 18'd0, 18'd0, 2'd1)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'hffffffff, 1'b0,
			18'd0, 18'd5, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'h0, 1'b0, 18'd0, 18'd0, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'h0, 1'b0, 18'd0, 18'd0, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'h0, 1'b0, 18'd0, 18'd1, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'h0, 1'b0,
			18'd0, 18'h3ffff, 2'd3)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'h0, 1'b1,
			18'h3ffff, 18'd0, 2'd3)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd3, 32'h0, 1'b0, 18'd0, 18'd0, 2'd0)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd7, 32'h0, 1'b0, 18'd0, 18'd0, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd7, 32'hffffffff, 1'b0,
			18'd0, 18'd0, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd2, 32'h0, 1'b1, 18'd0, 18'd0, 2'd2)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd9, 32'h0, 1'b0, 18'd0, 18'd0, 2'd3)};
		pending_q = {pending_q, make_item(14'd5, 14'd5, 16'd9, 32'h0, 1'b1, 18'h1, 18'd0, 2'd1)};
		// random keys on a few hot columns so buckets collide
		for (int i = 0; i < 12; i++) begin
			kc0[i] = (i == 11) ? 14'h3fff : 14'($urandom_range(0, 3));
			kc1[i] = (i == 10) ? 14'h3fff : 14'($urandom_range(0, 3));
			kfp[i] = (i == 9) ? 16'hffff : 16'($urandom);
		end
		for (int i = 0; i < 600; i++) begin
			k = $urandom_range(0, 11);
			mode = $urandom_range(0, 3);
			rnd = (mode == 0) ? $urandom : (mode == 1) ? 32'($urandom_range(0, 1 << 24)) :
				(mode == 2) ? 32'h0 : 32'hffffffff;
			kc = ($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($urandom_range(0, 40));
			sm = ($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($urandom_range(0, 40));
			if ($urandom_range(0, 19) == 0)
				pending_q = {pending_q, make_item(14'($urandom), 14'($urandom),
					16'($urandom), rnd, 1'($urandom), kc, sm, 2'($urandom))};
			else
				pending_q = {pending_q, make_item(kc0[k], kc1[k], kfp[k], rnd, 1'($urandom),
					kc, sm, 2'($urandom_range(0, 3)))};
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() > 80) @(posedge clk);
		calm = 1'b1;
		while (pending_q.size() > 0 || in_valid) @(posedge clk);
		while (result_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d transactions, %0d results: %0d increments, %0d claims,",
			accepted, checked, n_inc, n_claim);
		$display("%0d decays, %0d takeovers, %0d pushes, %0d updates",
			n_decay, n_take, n_push, n_upd);
		if (errors == 0 && result_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hkbu_pkg.sv
rtl/hkbu_front.sv
rtl/hkbu_queue.sv
rtl/hkbu_back.sv
rtl/heavy_keeper_bucket_update.sv
verif/heavy_keeper_bucket_update_tb.sv
